>>> rtl/core/periodic_event_timer_table_defines.svh
`ifndef PERIODIC_EVENT_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_EVENT_TIMER_TABLE_DEFINES_SVH

// Invariant checked at every edge outside reset.
`define PETT_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("pett invariant violated");

// Consequence required in the cycle after the trigger.
`define PETT_ASSERT_NEXT(label, trig, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (expr)) \
        else $error("pett sequence violated");

`endif

>>> rtl/core/pett_pkg.sv
`default_nettype none

package pett_pkg;

    localparam int MAX_EVENTS_DEF = 8;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [2:0] KIND_EXECUTE  = 3'd0;
    localparam logic [2:0] KIND_FINISH   = 3'd1;
    localparam logic [2:0] KIND_ACCEPTED = 3'd2;
    localparam logic [2:0] KIND_REJECTED = 3'd3;
    localparam logic [2:0] KIND_DONE     = 3'd4;

    localparam int REC_W = 130;

    typedef struct packed {
        logic [31:0] period;
        logic [30:0] run_length;
        logic        has_duration;
        logic        enabled;
        logic        started;
        logic [31:0] next_fire;
        logic [31:0] stop_time;
    } rec_t;

    typedef enum logic [3:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_ADD,
        COND_UPDATE,
        COND_TICK,
        COND_FULL,
        COND_BAD_SLOT,
        COND_WALK_DONE,
        COND_NO_FINISH,
        COND_NO_EXECUTE
    } cond_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_SLOT,
        RD_INDEX
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_ADD,
        WR_UPDATE,
        WR_TICK
    } wr_sel_t;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_REQ,
        SRC_COUNT,
        SRC_INDEX
    } slot_src_t;

    typedef struct packed {
        logic       accept;
        rd_sel_t    rd;
        wr_sel_t    wr;
        logic       eval;
        logic       emit;
        logic [2:0] kind;
        slot_src_t  slot_src;
        logic       last;
        logic       count_inc;
        logic       index_inc;
        cond_t      cond;
        logic [4:0] target;
    } ctrl_t;

    // program labels
    localparam logic [4:0] STEP_IN       = 5'd0;
    localparam logic [4:0] STEP_IS_ADD   = 5'd1;
    localparam logic [4:0] STEP_IS_UPD   = 5'd2;
    localparam logic [4:0] STEP_IS_TICK  = 5'd3;
    localparam logic [4:0] STEP_REJ_ZERO = 5'd4;
    localparam logic [4:0] STEP_ADD_CHK  = 5'd5;
    localparam logic [4:0] STEP_ADD_WR   = 5'd6;
    localparam logic [4:0] STEP_UPD_CHK  = 5'd7;
    localparam logic [4:0] STEP_UPD_RD   = 5'd8;
    localparam logic [4:0] STEP_UPD_WR   = 5'd9;
    localparam logic [4:0] STEP_UPD_REJ  = 5'd10;
    localparam logic [4:0] STEP_WALK     = 5'd11;
    localparam logic [4:0] STEP_SLOT_RD  = 5'd12;
    localparam logic [4:0] STEP_EVAL     = 5'd13;
    localparam logic [4:0] STEP_FINISH   = 5'd14;
    localparam logic [4:0] STEP_WRBACK   = 5'd15;
    localparam logic [4:0] STEP_EXECUTE  = 5'd16;
    localparam logic [4:0] STEP_ADVANCE  = 5'd17;
    localparam logic [4:0] STEP_DONE     = 5'd18;

    function automatic ctrl_t ucode(input logic [4:0] step);
        ctrl_t c;
        c = '0;
        c.rd       = RD_NONE;
        c.wr       = WR_NONE;
        c.slot_src = SRC_ZERO;
        c.cond     = COND_NEXT;
        unique case (step)
            STEP_IN: begin
                c.accept = 1'b1;
            end
            STEP_IS_ADD: begin
                c.cond = COND_ADD;    c.target = STEP_ADD_CHK;
            end
            STEP_IS_UPD: begin
                c.cond = COND_UPDATE; c.target = STEP_UPD_CHK;
            end
            STEP_IS_TICK: begin
                c.cond = COND_TICK;   c.target = STEP_WALK;
            end
            STEP_REJ_ZERO: begin
                c.emit = 1'b1; c.kind = KIND_REJECTED; c.last = 1'b1;
                c.cond = COND_ALWAYS; c.target = STEP_IN;
            end
            STEP_ADD_CHK: begin
                c.cond = COND_FULL;   c.target = STEP_REJ_ZERO;
            end
            STEP_ADD_WR: begin
                c.wr = WR_ADD; c.count_inc = 1'b1;
                c.emit = 1'b1; c.kind = KIND_ACCEPTED; c.slot_src = SRC_COUNT;
                c.last = 1'b1;
                c.cond = COND_ALWAYS; c.target = STEP_IN;
            end
            STEP_UPD_CHK: begin
                c.cond = COND_BAD_SLOT; c.target = STEP_UPD_REJ;
            end
            STEP_UPD_RD: begin
                c.rd = RD_SLOT;
            end
            STEP_UPD_WR: begin
                c.wr = WR_UPDATE;
                c.emit = 1'b1; c.kind = KIND_ACCEPTED; c.slot_src = SRC_REQ;
                c.last = 1'b1;
                c.cond = COND_ALWAYS; c.target = STEP_IN;
            end
            STEP_UPD_REJ: begin
                c.emit = 1'b1; c.kind = KIND_REJECTED; c.slot_src = SRC_REQ;
                c.last = 1'b1;
                c.cond = COND_ALWAYS; c.target = STEP_IN;
            end
            STEP_WALK: begin
                c.cond = COND_WALK_DONE; c.target = STEP_DONE;
            end
            STEP_SLOT_RD: begin
                c.rd = RD_INDEX;
            end
            STEP_EVAL: begin
                c.eval = 1'b1;
                c.cond = COND_NO_FINISH; c.target = STEP_WRBACK;
            end
            STEP_FINISH: begin
                c.emit = 1'b1; c.kind = KIND_FINISH; c.slot_src = SRC_INDEX;
            end
            STEP_WRBACK: begin
                c.wr = WR_TICK;
                c.cond = COND_NO_EXECUTE; c.target = STEP_ADVANCE;
            end
            STEP_EXECUTE: begin
                c.emit = 1'b1; c.kind = KIND_EXECUTE; c.slot_src = SRC_INDEX;
            end
            STEP_ADVANCE: begin
                c.index_inc = 1'b1;
                c.cond = COND_ALWAYS; c.target = STEP_WALK;
            end
            STEP_DONE: begin
                c.emit = 1'b1; c.kind = KIND_DONE; c.last = 1'b1;
                c.cond = COND_ALWAYS; c.target = STEP_IN;
            end
            default: begin
                c.cond = COND_ALWAYS; c.target = STEP_IN;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/pett_ram.sv
`default_nettype none

module pett_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   aclk,
    input  wire logic                   we,
    input  wire logic [AW-1:0]          waddr,
    input  wire logic [WIDTH-1:0]       wdata,
    input  wire logic                   re,
    input  wire logic [AW-1:0]          raddr,
    output logic      [WIDTH-1:0]       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/periodic_event_timer_table.sv
`default_nettype none
// Channel   Ports                                       Direction
// s_        operation slot now period has_duration      in, valid/ready
//           run_length enabled
// m_        kind slot_out last                          out, valid/ready
//
// Add, update, unknown operation and tick each run as a sequence of
// microcode steps from the step counter, with a registered read of the
// slot RAM (at most one access per step); a tick walks every filled slot.
// A request is taken only at the program's input step; an emitting step
// waits while the result register is still held by m_ready low.
// aresetn clears the step counter, fill count and result valid; slot RAM
// contents are only read for filled slots.
`include "periodic_event_timer_table_defines.svh"

module periodic_event_timer_table #(
    parameter int MAX_EVENTS = pett_pkg::MAX_EVENTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [2:0]  s_slot,
    input  wire logic [31:0] s_now,
    input  wire logic [31:0] s_period,
    input  wire logic        s_has_duration,
    input  wire logic [30:0] s_run_length,
    input  wire logic        s_enabled,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [2:0]  m_kind,
    output logic      [2:0]  m_slot_out,
    output logic             m_last
);
    localparam int CW = $clog2(MAX_EVENTS + 1);
    localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;

    pett_pkg::ctrl_t c;

    logic [4:0]     pc_reg, pc_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  index_reg, index_next;

    logic [1:0]     op_reg;
    logic [2:0]     slot_reg;
    logic [31:0]    now_reg, period_reg;
    logic           dur_reg, en_reg;
    logic [30:0]    runl_reg;

    pett_pkg::rec_t work_reg, work_next;
    logic           fin_reg, fin_next;
    logic           exe_reg, exe_next;

    logic           m_valid_reg, m_valid_next;
    logic [2:0]     m_kind_reg, m_slot_out_reg;
    logic           m_last_reg;

    logic           out_free, go, jump, emit_fire;
    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    pett_pkg::rec_t ram_wdata, ram_rdata;
    logic [2:0]     emit_slot;

    logic           start_now;
    logic [31:0]    stop_new;

    assign c = pett_pkg::ucode(pc_reg);

    assign out_free  = !m_valid_reg || m_ready;
    assign go        = (!c.emit || out_free) && (!c.accept || s_valid);
    assign emit_fire = go && c.emit;
    assign s_ready   = c.accept;

    always_comb begin
        unique case (c.cond)
            pett_pkg::COND_NEXT:       jump = 1'b0;
            pett_pkg::COND_ALWAYS:     jump = 1'b1;
            pett_pkg::COND_ADD:        jump = (op_reg == pett_pkg::OP_ADD);
            pett_pkg::COND_UPDATE:     jump = (op_reg == pett_pkg::OP_UPDATE);
            pett_pkg::COND_TICK:       jump = (op_reg == pett_pkg::OP_TICK);
            pett_pkg::COND_FULL:       jump = (count_reg >= CW'(MAX_EVENTS));
            pett_pkg::COND_BAD_SLOT:   jump = (32'(slot_reg) >= 32'(count_reg));
            pett_pkg::COND_WALK_DONE:  jump = (index_reg >= count_reg);
            pett_pkg::COND_NO_FINISH:  jump = !fin_next;
            pett_pkg::COND_NO_EXECUTE: jump = !exe_reg;
            default:                   jump = 1'b0;
        endcase
    end

    always_comb begin
        pc_next = pc_reg;
        if (go) begin
            pc_next = jump ? c.target : pc_reg + 5'd1;
        end
    end

    always_comb begin
        count_next = count_reg;
        index_next = index_reg;
        if (go && c.count_inc) begin
            count_next = count_reg + CW'(1);
        end
        if (go && c.accept) begin
            index_next = '0;
        end else if (go && c.index_inc) begin
            index_next = index_reg + CW'(1);
        end
    end

    // per-slot tick evaluation on the record just read
    always_comb begin
        start_now = ram_rdata.enabled && ram_rdata.has_duration && !ram_rdata.started;
        stop_new  = start_now ? now_reg + {1'b0, ram_rdata.run_length}
                              : ram_rdata.stop_time;
        fin_next  = ram_rdata.enabled && ram_rdata.has_duration && (now_reg >= stop_new);
        exe_next  = ram_rdata.enabled && (now_reg >= ram_rdata.next_fire);
        work_next = ram_rdata;
        work_next.enabled   = ram_rdata.enabled && !fin_next;
        work_next.started   = (ram_rdata.started || start_now) && !fin_next;
        work_next.stop_time = stop_new;
        work_next.next_fire = exe_next ? now_reg + ram_rdata.period : ram_rdata.next_fire;
    end

    always_comb begin
        ram_re    = go && (c.rd != pett_pkg::RD_NONE);
        ram_raddr = (c.rd == pett_pkg::RD_SLOT) ? AW'(slot_reg) : index_reg[AW-1:0];
        ram_we    = go && (c.wr != pett_pkg::WR_NONE);
        ram_waddr = index_reg[AW-1:0];
        ram_wdata = work_reg;
        unique case (c.wr)
            pett_pkg::WR_ADD: begin
                ram_waddr = count_reg[AW-1:0];
                ram_wdata = '{period: period_reg, run_length: runl_reg,
                              has_duration: dur_reg, enabled: en_reg, started: 1'b0,
                              next_fire: now_reg, stop_time: now_reg};
            end
            pett_pkg::WR_UPDATE: begin
                ram_waddr = AW'(slot_reg);
                ram_wdata = ram_rdata;
                ram_wdata.period       = period_reg;
                ram_wdata.run_length   = runl_reg;
                ram_wdata.has_duration = dur_reg;
                ram_wdata.enabled      = en_reg;
            end
            pett_pkg::WR_TICK: begin
                ram_waddr = index_reg[AW-1:0];
                ram_wdata = work_reg;
            end
            default: begin
                ram_waddr = index_reg[AW-1:0];
                ram_wdata = work_reg;
            end
        endcase
    end

    always_comb begin
        unique case (c.slot_src)
            pett_pkg::SRC_ZERO:  emit_slot = 3'd0;
            pett_pkg::SRC_REQ:   emit_slot = slot_reg;
            pett_pkg::SRC_COUNT: emit_slot = 3'(count_reg);
            pett_pkg::SRC_INDEX: emit_slot = 3'(index_reg);
            default:             emit_slot = 3'd0;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    pett_ram #(
        .WIDTH (pett_pkg::REC_W),
        .DEPTH (MAX_EVENTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= pett_pkg::STEP_IN;
            count_reg   <= '0;
            index_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            count_reg   <= count_next;
            index_reg   <= index_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg     <= s_operation;
            slot_reg   <= s_slot;
            now_reg    <= s_now;
            period_reg <= s_period;
            dur_reg    <= s_has_duration;
            runl_reg   <= s_run_length;
            en_reg     <= s_enabled;
        end
        if (go && c.eval) begin
            work_reg <= work_next;
            fin_reg  <= fin_next;
            exe_reg  <= exe_next;
        end
        if (emit_fire) begin
            m_kind_reg     <= c.kind;
            m_slot_out_reg <= emit_slot;
            m_last_reg     <= c.last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_slot_out = m_slot_out_reg;
    assign m_last     = m_last_reg;

    `PETT_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(MAX_EVENTS))
    `PETT_ASSERT_ALWAYS(a_index_bound, index_reg <= count_reg)
    `PETT_ASSERT_NEXT(a_last_to_input, emit_fire && c.last, pc_reg == pett_pkg::STEP_IN)
    `PETT_ASSERT_NEXT(a_finish_seen, go && pc_reg == pett_pkg::STEP_FINISH, !fin_reg || !work_reg.enabled)

endmodule

`default_nettype wire
